// File: rtl/fifo_queue_with_delete_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle queue
// Shared property wrappers; every use is clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_DELETE_CORE_DEFINES_SVH

// Same-cycle implication.
`define FQD_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg
// Types and constants shared by the handle queue modules.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned REQ_VALUE_BITS  = 32;
  localparam int unsigned OUT_VALUE_BITS  = 32;
  localparam int unsigned COUNT_BITS      = 5;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_ITERATE = 2'd3
  } fqd_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } fqd_status_e;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_DEQ    = 3'd1,
    BK_SCAN   = 3'd2,
    BK_SHIFT  = 3'd3,
    BK_ITER   = 3'd4,
    BK_REPORT = 3'd5
  } fqd_state_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [REQ_VALUE_BITS-1:0] item_value;
  } fqd_req_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [OUT_VALUE_BITS-1:0] out_value;
    logic [COUNT_BITS-1:0]     entry_count;
    logic                      last_of_run;
  } fqd_rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    fqd_op_e op;
    logic    val_null;
  } fqd_cmd_t;

endpackage

// File: rtl/fqd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fqd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_front
// Request intake: classify each request and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module fqd_front import fqd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fqd_req_t              req_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  output fqd_cmd_t              cmd_o,
  output logic [VALUE_BITS-1:0] cmd_value_o,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i
);

  localparam int unsigned QD = 2;
  localparam int unsigned PW = $clog2(QD);
  localparam int unsigned FW = $clog2(QD + 1);

  fqd_cmd_t              cmd_q [QD];
  logic [VALUE_BITS-1:0] val_q [QD];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]         fill_q, fill_d;

  fqd_cmd_t              in_cmd;
  logic [VALUE_BITS-1:0] in_val;
  logic                  push, pop;

  // Mask the handle to the stored width and flag the null handle.
  always_comb begin
    in_val          = VALUE_BITS'(req_i.item_value);
    in_cmd.op       = fqd_op_e'(req_i.req_type);
    in_cmd.val_null = (in_val == '0);
  end

  assign req_ready_o = (fill_q != FW'(QD));
  assign cmd_valid_o = (fill_q != '0);
  assign push        = req_valid_i && req_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign cmd_value_o = val_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    case ({push, pop})
      2'b10:   fill_d = fill_q + FW'(1);
      2'b01:   fill_d = fill_q - FW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= in_cmd;
      val_q[wr_ptr_q] <= in_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: rtl/fqd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_back
// Request execution over a circular entry RAM, with a result register.
// ----------------------------------------------------------------------------
module fqd_back import fqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fqd_cmd_t              cmd_i,
  input  logic [VALUE_BITS-1:0] cmd_value_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  output fqd_rsp_t              rsp_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);

  fqd_state_e            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  fqd_status_e           pend_status_q, pend_status_d;
  logic                  pend_dec_q, pend_dec_d;
  fqd_rsp_t              rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  logic                  out_free;
  logic [AW-1:0]         last_idx, idx_next;

  // Logical position to RAM slot, wrapping around the end of the store.
  function automatic logic [AW-1:0] phys_addr(logic [AW-1:0] base, logic [AW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic fqd_rsp_t make_rsp(fqd_status_e st, logic [VALUE_BITS-1:0] v,
                                        logic [CW-1:0] cnt, logic last);
    fqd_rsp_t r;
    r.status      = st;
    r.out_value   = OUT_VALUE_BITS'(v);
    r.entry_count = COUNT_BITS'(cnt);
    r.last_of_run = last;
    return r;
  endfunction

  fqd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign last_idx = AW'(count_q - CW'(1));
  assign idx_next = idx_q + AW'(1);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    val_d         = val_q;
    pend_status_d = pend_status_q;
    pend_dec_d    = pend_dec_q;
    rsp_d         = rsp_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    cmd_ready_o   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = phys_addr(head_q, idx_q);
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = phys_addr(head_q, idx_next);

    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          val_d = cmd_value_i;
          idx_d = '0;
          unique case (cmd_i.op)
            OP_ENQUEUE: begin
              rsp_valid_d = 1'b1;
              if (cmd_i.val_null) begin
                rsp_d = make_rsp(ST_NULL, '0, count_q, 1'b1);
              end else if (count_q == FULL_COUNT) begin
                rsp_d = make_rsp(ST_FULL, '0, count_q, 1'b1);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr(head_q, AW'(count_q));
                ram_wdata = cmd_value_i;
                count_d   = count_q + CW'(1);
                rsp_d     = make_rsp(ST_OK, '0, count_d, 1'b1);
              end
            end
            OP_DEQUEUE: begin
              if (count_q == '0) begin
                rsp_valid_d = 1'b1;
                rsp_d       = make_rsp(ST_EMPTY, '0, count_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = BK_DEQ;
              end
            end
            OP_DELETE: begin
              if (cmd_i.val_null) begin
                rsp_valid_d = 1'b1;
                rsp_d       = make_rsp(ST_NULL, '0, count_q, 1'b1);
              end else if (count_q == '0) begin
                rsp_valid_d = 1'b1;
                rsp_d       = make_rsp(ST_NOT_FOUND, '0, count_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = BK_SCAN;
              end
            end
            OP_ITERATE: begin
              if (count_q == '0) begin
                rsp_valid_d = 1'b1;
                rsp_d       = make_rsp(ST_EMPTY, '0, count_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = BK_ITER;
              end
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end

      BK_DEQ: begin
        if (out_free) begin
          count_d     = count_q - CW'(1);
          head_d      = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
          rsp_valid_d = 1'b1;
          rsp_d       = make_rsp(ST_OK, ram_rdata, count_d, 1'b1);
          state_d     = BK_IDLE;
        end
      end

      // Compare one entry per cycle while the next one is read.
      BK_SCAN: begin
        if (ram_rdata == val_q) begin
          pend_status_d = ST_OK;
          pend_dec_d    = 1'b1;
          if (idx_q == last_idx) begin
            state_d = BK_REPORT;
          end else begin
            ram_re  = 1'b1;
            state_d = BK_SHIFT;
          end
        end else if (idx_q == last_idx) begin
          pend_status_d = ST_NOT_FOUND;
          pend_dec_d    = 1'b0;
          state_d       = BK_REPORT;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_next;
        end
      end

      // Close the gap: read data holds entry idx+1, write it to idx.
      BK_SHIFT: begin
        ram_we = 1'b1;
        if (idx_next == last_idx) begin
          state_d = BK_REPORT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys_addr(head_q, idx_next + AW'(1));
          idx_d     = idx_next;
        end
      end

      BK_ITER: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = make_rsp(ST_OK, ram_rdata, count_q, idx_q == last_idx);
          if (idx_q == last_idx) begin
            state_d = BK_IDLE;
          end else begin
            ram_re = 1'b1;
            idx_d  = idx_next;
          end
        end
      end

      BK_REPORT: begin
        if (out_free) begin
          count_d     = count_q - CW'(pend_dec_q);
          rsp_valid_d = 1'b1;
          rsp_d       = make_rsp(pend_status_q, '0, count_d, 1'b1);
          state_d     = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q         <= val_d;
    pend_status_q <= pend_status_d;
    pend_dec_q    <= pend_dec_d;
    rsp_q         <= rsp_d;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: rtl/fifo_queue_with_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_core
// Bounded queue of nonzero handles with enqueue, dequeue, delete and iterate.
// ----------------------------------------------------------------------------
// A request enters a two-entry intake queue and is run by the back end, which
// keeps the entries in a circular RAM with one write and one registered read
// port. Enqueue, and any request answered before an entry is read (null
// handle, full queue, empty queue), is answered from the idle state; dequeue
// first reads the head entry, then answers. Delete walks the entries from the
// head, one per cycle, until it finds the handle, then moves every later entry
// one place towards the head, again one per cycle; found or not, it ends in a
// report state that gives the result. Iterate first reads the head entry, then
// gives one result per cycle, head to tail, while results are taken, the last
// one marked. A result waits in an output register; the intake queue keeps
// taking requests meanwhile, while it has room. Every result carries the count
// after the request. Reset clears the state, count, pointers and result valid
// flag; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_core import fqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fqd_req_t req_i,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output fqd_rsp_t rsp_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i
);

  // Classified request between intake and execution.
  fqd_cmd_t              cmd;
  logic [VALUE_BITS-1:0] cmd_value;
  logic                  cmd_valid;
  logic                  cmd_ready;

  // Intake: mask the handle, flag null, queue the request.
  fqd_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .cmd_o       (cmd),
    .cmd_value_o (cmd_value),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // Execution: walk the entry RAM and drive the result register.
  fqd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_value_i (cmd_value),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i)
  );

endmodule

// File: rtl/fqd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks on the result channel of the handle queue.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_core_defines.svh"

module fqd_checker import fqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input fqd_rsp_t rsp_i,
  input logic     rsp_valid_i,
  input logic     rsp_ready_i
);

  `FQD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_i), "result changed while stalled")
  `FQD_ASSERT_IMPL(a_full_count, clk_i, rst_ni, rsp_valid_i && (rsp_i.status == ST_FULL), rsp_i.entry_count == COUNT_BITS'(QUEUE_DEPTH), "full status with wrong count")
  `FQD_ASSERT_IMPL(a_error_single, clk_i, rst_ni, rsp_valid_i && (rsp_i.status != ST_OK), (rsp_i.out_value == '0) && rsp_i.last_of_run, "error result carries a value or is not last")
  `FQD_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rsp_valid_i && (rsp_i.status == ST_EMPTY), rsp_i.entry_count == '0, "empty status with nonzero count")

endmodule

bind fifo_queue_with_delete_core fqd_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_i       (rsp_o),
  .rsp_valid_i (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handle queue with enqueue, dequeue, delete and
// iterate. A behavioural copy of the queue predicts every result. Each
// returned result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import fqd_pkg::*;

  localparam int unsigned DEPTH         = QUEUE_DEPTH_DEF;
  localparam int unsigned VBITS         = VALUE_BITS_DEF;
  localparam int          CYCLE_LIMIT   = 1000000;
  // Worst request walks the whole store, plus margin for the output register.
  localparam int          SETTLE_CYCLES = 4 * DEPTH + 8;

  logic     clk_i;
  logic     rst_ni;
  fqd_req_t req_i;
  logic     req_valid_i;
  logic     req_ready_o;
  fqd_rsp_t rsp_o;
  logic     rsp_valid_o;
  logic     rsp_ready_i;

  // Behavioural copy of the held handles, head first.
  logic [VBITS-1:0] held_handles[$];
  // Predicted results, oldest first.
  fqd_rsp_t         pending_rsp[$];

  int err_count;
  int sent_count;
  int result_count;
  int op_seen[4];
  int status_seen[5];
  int max_fill;

  // Sender burst control: when bursty, send a run of requests, then rest.
  bit sender_bursty;
  int burst_left;
  // Receiver pattern: 0 always ready, 1 short random stalls, 2 long stalls.
  int rsp_mode;

  fifo_queue_with_delete_core #(
    .QUEUE_DEPTH(DEPTH),
    .VALUE_BITS (VBITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i)
  );

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run; a hung handshake ends here.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[%0t] timeout after %0d cycles, %0d results outstanding",
             $time, CYCLE_LIMIT, pending_rsp.size());
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Queue predictor
  // --------------------------------------------------------------------------
  // Build one result; the count is always the one after the request.
  function automatic fqd_rsp_t queue_result(input fqd_status_e st,
                                            input logic [OUT_VALUE_BITS-1:0] value,
                                            input logic last);
    fqd_rsp_t r;
    r.status      = st;
    r.out_value   = value;
    r.entry_count = COUNT_BITS'(held_handles.size());
    r.last_of_run = last;
    status_seen[st]++;
    return r;
  endfunction

  // Apply one accepted request to the copy and queue the results it causes.
  task automatic predict_queue_results(input fqd_req_t r);
    logic [VBITS-1:0] value;
    logic [VBITS-1:0] head;
    int               hit;
    value = r.item_value[VBITS-1:0];
    hit   = -1;
    op_seen[r.req_type]++;
    case (fqd_op_e'(r.req_type))
      OP_ENQUEUE: begin
        if (value == '0) begin
          pending_rsp.push_back(queue_result(ST_NULL, '0, 1'b1));
        end else if (held_handles.size() >= DEPTH) begin
          pending_rsp.push_back(queue_result(ST_FULL, '0, 1'b1));
        end else begin
          held_handles.push_back(value);
          pending_rsp.push_back(queue_result(ST_OK, '0, 1'b1));
        end
      end
      OP_DEQUEUE: begin
        if (held_handles.size() == 0) begin
          pending_rsp.push_back(queue_result(ST_EMPTY, '0, 1'b1));
        end else begin
          head = held_handles.pop_front();
          pending_rsp.push_back(queue_result(ST_OK, head, 1'b1));
        end
      end
      OP_DELETE: begin
        if (value == '0) begin
          pending_rsp.push_back(queue_result(ST_NULL, '0, 1'b1));
        end else begin
          // Remove only the first match, nearest the head.
          for (int i = 0; i < held_handles.size(); i++) begin
            if (hit < 0 && held_handles[i] == value) hit = i;
          end
          if (hit < 0) begin
            pending_rsp.push_back(queue_result(ST_NOT_FOUND, '0, 1'b1));
          end else begin
            held_handles.delete(hit);
            pending_rsp.push_back(queue_result(ST_OK, '0, 1'b1));
          end
        end
      end
      default: begin
        if (held_handles.size() == 0) begin
          pending_rsp.push_back(queue_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < held_handles.size(); i++) begin
            pending_rsp.push_back(queue_result(ST_OK, held_handles[i],
                                               i == held_handles.size() - 1));
          end
        end
      end
    endcase
    if (held_handles.size() > max_fill) max_fill = held_handles.size();
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Call at a falling edge; returns at the falling edge after acceptance with
  // valid high so the next request keeps it up, unless a rest drops it.
  task automatic send_request(input fqd_op_e op, input logic [REQ_VALUE_BITS-1:0] value);
    int gap;
    req_i.req_type   = op;
    req_i.item_value = value;
    req_valid_i      = 1'b1;
    // Hold payload until the queue takes the request.
    do @(posedge clk_i); while (!req_ready_o);
    predict_queue_results(req_i);
    sent_count++;
    @(negedge clk_i);
    if (sender_bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // Rest between bursts; the next burst length is drawn afresh.
        gap         = $urandom_range(1, 6);
        req_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left  = $urandom_range(0, 7);
      end
    end
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_for_drain();
    req_valid_i = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver and checker
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    rsp_ready_i = 1'b0;
    hold        = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rsp_mode == 0) begin
        rsp_ready_i = 1'b1;
        hold        = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (rsp_mode == 1) begin
        rsp_ready_i = 1'($urandom_range(0, 1));
        hold        = $urandom_range(0, 2);
      end else begin
        // Long stalls with short windows of readiness.
        rsp_ready_i = ~rsp_ready_i;
        hold        = rsp_ready_i ? $urandom_range(0, 3) : $urandom_range(2, 20);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fqd_rsp_t want;
    if (rst_ni && rsp_valid_o === 1'b1 && rsp_ready_i) begin
      result_count++;
      if (pending_rsp.size() == 0) begin
        $display("[%0t] unexpected result: status %0d value %h count %0d last %0d",
                 $time, rsp_o.status, rsp_o.out_value, rsp_o.entry_count,
                 rsp_o.last_of_run);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          $display("[%0t] status mismatch: expected %0d, actual %0d",
                   $time, want.status, rsp_o.status);
          err_count++;
        end
        if (rsp_o.out_value !== want.out_value) begin
          $display("[%0t] out_value mismatch: expected %h, actual %h",
                   $time, want.out_value, rsp_o.out_value);
          err_count++;
        end
        if (rsp_o.entry_count !== want.entry_count) begin
          $display("[%0t] entry_count mismatch: expected %0d, actual %0d",
                   $time, want.entry_count, rsp_o.entry_count);
          err_count++;
        end
        if (rsp_o.last_of_run !== want.last_of_run) begin
          $display("[%0t] last_of_run mismatch: expected %0d, actual %0d",
                   $time, want.last_of_run, rsp_o.last_of_run);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every error path of an empty queue, plus the null handle for both users.
  task automatic test_empty_queue();
    send_request(OP_DEQUEUE, 32'hFFFF_FFFF);   // value is ignored
    send_request(OP_ITERATE, 32'h0000_0000);
    send_request(OP_DELETE,  32'h1234_5678);   // missing in an empty queue
    send_request(OP_DELETE,  32'h0000_0000);   // null delete
    send_request(OP_ENQUEUE, 32'h0000_0000);   // null enqueue
  endtask

  // Fill with extreme and duplicated handles, overflow once, then list all.
  task automatic test_fill_to_full();
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
        1:       send_request(OP_ENQUEUE, 32'h0000_0001);
        2:       send_request(OP_ENQUEUE, 32'h8000_0000);
        3, 9:    send_request(OP_ENQUEUE, 32'hA5A5_A5A5);
        default: send_request(OP_ENQUEUE, $urandom | 32'h1);
      endcase
    end
    send_request(OP_ENQUEUE, 32'h5A5A_5A5A);   // full enqueue
    send_request(OP_ITERATE, 32'hFFFF_FFFF);   // value is ignored
  endtask

  // Delete a duplicate (first match only), the tail and the head.
  task automatic test_delete_positions();
    logic [VBITS-1:0] tail;
    tail = held_handles[held_handles.size() - 1];
    send_request(OP_DELETE, 32'hA5A5_A5A5);
    send_request(OP_DELETE, tail);
    send_request(OP_DELETE, 32'hFFFF_FFFF);
  endtask

  // Handle generator: mostly well-formed, with nulls and small colliding values.
  function automatic logic [VBITS-1:0] pick_handle();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k < 5 && held_handles.size() > 0)
      return held_handles[$urandom_range(0, held_handles.size() - 1)];
    if (k < 10) return VBITS'($urandom_range(1, 8));
    return $urandom;
  endfunction

  // Random traffic with a chosen enqueue share to steer the fill level.
  task automatic test_random_traffic(input int count, input int enq_pct);
    int               roll;
    logic [VBITS-1:0] target;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        send_request(OP_ENQUEUE, pick_handle());
      end else if (roll < enq_pct + 25) begin
        // Delete mostly held handles so the shift path is walked often.
        if (held_handles.size() > 0 && $urandom_range(0, 9) < 7)
          target = held_handles[$urandom_range(0, held_handles.size() - 1)];
        else
          target = pick_handle();
        send_request(OP_DELETE, target);
      end else if (roll < enq_pct + 37) begin
        send_request(OP_ITERATE, $urandom);
      end else begin
        send_request(OP_DEQUEUE, $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst_ni        = 1'b0;
    req_valid_i   = 1'b0;
    req_i         = '0;
    err_count     = 0;
    sent_count    = 0;
    result_count  = 0;
    max_fill      = 0;
    sender_bursty = 1'b0;
    burst_left    = 0;
    rsp_mode      = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: back to back; receiver always ready, then short stalls for deletes.
    test_empty_queue();
    test_fill_to_full();
    rsp_mode = 1;
    test_delete_positions();
    wait_for_drain();

    // Enqueue-heavy traffic: sit at full, with bursts and short stalls.
    sender_bursty = 1'b1;
    test_random_traffic(100, 55);
    wait_for_drain();

    // Dequeue-heavy traffic drains to empty; long receiver stalls.
    rsp_mode = 2;
    test_random_traffic(100, 15);
    wait_for_drain();

    // Balanced traffic with no idling on either side.
    sender_bursty = 1'b0;
    rsp_mode      = 0;
    test_random_traffic(100, 40);
    wait_for_drain();

    // Balanced traffic with idling on both sides.
    sender_bursty = 1'b1;
    rsp_mode      = 1;
    test_random_traffic(100, 40);

    // Drain, keep the receiver open and watch for stray results.
    wait_for_drain();
    rsp_mode = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (enq %0d, deq %0d, del %0d, iter %0d), %0d results.",
             sent_count, op_seen[OP_ENQUEUE], op_seen[OP_DEQUEUE], op_seen[OP_DELETE],
             op_seen[OP_ITERATE], result_count);
    $display("Status mix ok %0d null %0d empty %0d not-found %0d full %0d; peak fill %0d.",
             status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL], max_fill);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
